### rtl/scr_pkg.sv
// Shared constants and types for the sync/CRC frame receiver.
`timescale 1ns / 1ps

package scr_pkg;

  localparam logic [7:0]  SYNC_LO       = 8'h55;
  localparam logic [7:0]  SYNC_HI       = 8'hAA;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          TIME_BYTES    = 8;
  localparam int          NUM_VALUES    = 14;
  localparam logic [5:0]  PAYLOAD_BYTES = 6'd36;
  localparam logic [5:0]  LAST_BYTE     = 6'd37;
  localparam logic [3:0]  LAST_INDEX    = 4'd13;

  typedef logic [NUM_VALUES-1:0][15:0] value_set_t;

  // Handoff of a checked frame from the framer to the output buffer.
  typedef struct packed {
    logic       load;
    logic [63:0] frame_time;
    value_set_t values;
  } frame_done_t;

endpackage

### rtl/scr_crc16.sv
// CRC-16/CCITT byte update, msb first.
`timescale 1ns / 1ps

module scr_crc16
  import scr_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

### rtl/scr_framer.sv
// Sync hunt, field capture and CRC check for incoming bytes.
`timescale 1ns / 1ps

module scr_framer
  import scr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic [7:0]  rx_byte,
  output logic        rx_stall,
  input  logic        out_busy,
  output frame_done_t done
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  logic [1:0]  phase;
  logic [5:0]  byte_count;
  logic [15:0] crc_acc;
  logic [15:0] crc_next;
  logic [63:0] time_reg;
  value_set_t  value_store;
  logic [7:0]  crc_low_byte;
  logic        accept;
  logic        at_tail;

  scr_crc16 u_crc (
    .crc_in  (crc_acc),
    .data    (rx_byte),
    .crc_out (crc_next)
  );

  assign at_tail = (phase == PH_BODY) && (byte_count >= LAST_BYTE);
  // Hold the closing byte while the previous frame still drains.
  assign rx_stall = at_tail && out_busy;
  assign accept   = rx_valid && !rx_stall;

  assign done.load = accept && (phase == PH_BODY) && (byte_count == LAST_BYTE) &&
                     ({rx_byte, crc_low_byte} == crc_acc);
  assign done.frame_time = time_reg;
  assign done.values     = value_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      crc_acc    <= CRC_INIT;
    end else if (accept) begin
      case (phase)
        PH_SYNC2: begin
          if (rx_byte == SYNC_HI) begin
            phase      <= PH_BODY;
            byte_count <= '0;
            crc_acc    <= CRC_INIT;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_BODY: begin
          if (byte_count < PAYLOAD_BYTES) begin
            crc_acc    <= crc_next;
            byte_count <= byte_count + 6'd1;
          end else if (byte_count == PAYLOAD_BYTES) begin
            byte_count <= byte_count + 6'd1;
          end else begin
            phase      <= PH_HUNT;
            byte_count <= '0;
          end
        end
        default: begin
          phase <= (rx_byte == SYNC_LO) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_BODY)) begin
      for (int i = 0; i < TIME_BYTES; i++) begin
        if (byte_count == 6'(i)) begin
          time_reg[8*i +: 8] <= rx_byte;
        end
      end
      for (int i = 0; i < NUM_VALUES; i++) begin
        if (byte_count == 6'(TIME_BYTES + 2*i)) begin
          value_store[i][7:0] <= rx_byte;
        end
        if (byte_count == 6'(TIME_BYTES + 2*i + 1)) begin
          value_store[i][15:8] <= rx_byte;
        end
      end
      if (byte_count == PAYLOAD_BYTES) begin
        crc_low_byte <= rx_byte;
      end
    end
  end

endmodule

### rtl/scr_out_buf.sv
// Result buffer that drains one checked frame, one value per word.
`timescale 1ns / 1ps

module scr_out_buf
  import scr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frame_done_t done,
  output logic        busy,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] frame_time,
  output logic [3:0]  value_index,
  output logic [15:0] joint_value,
  output logic        last_value
);

  logic [3:0]  idx;
  logic [63:0] time_hold;
  value_set_t  vals;
  logic        drain;

  assign drain       = busy && !res_stall;
  assign res_valid   = busy;
  assign frame_time  = time_hold;
  assign value_index = idx;
  assign joint_value = vals[0];
  assign last_value  = (idx == LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (done.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (drain) begin
      if (idx == LAST_INDEX) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done.load) begin
      time_hold <= done.frame_time;
      vals      <= done.values;
    end else if (drain) begin
      // advance: shift the next value into the head slot
      for (int i = 0; i < NUM_VALUES - 1; i++) begin
        vals[i] <= vals[i+1];
      end
    end
  end

endmodule

### rtl/sync_crc_frame_receiver.sv
// Top level of the sync-word frame receiver with CRC-16 check.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  rx      | in        | rx_valid / rx_stall  | rx_byte
//  res     | out       | res_valid / res_stall| frame_time, value_index, joint_value,
//          |           |                      | last_value
//
// One received byte per cycle while rx_stall is low: sync hunt, field capture and the CRC byte
// update are a single level of logic ahead of the state registers.
// A frame with a good CRC yields fourteen result words, one per cycle from the output
// buffer while res_stall is low, starting the cycle after the closing CRC byte is taken.
// The closing byte of the next frame is stalled only while the buffer still drains.
// Reset (rst, synchronous) returns to sync hunting; no clearing pass is needed.
// A stalled result word holds its payload until taken.
`timescale 1ns / 1ps

module sync_crc_frame_receiver
  import scr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] frame_time,
  output logic [3:0]  value_index,
  output logic [15:0] joint_value,
  output logic        last_value
);

  frame_done_t done;
  logic        out_busy;

  // Frame state: hunt for the sync pair, collect fields, check the CRC.
  scr_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .out_busy (out_busy),
    .done     (done)
  );

  // Copy of a good frame, drained one word per accepted handshake.
  scr_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .busy        (out_busy),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .frame_time  (frame_time),
    .value_index (value_index),
    .joint_value (joint_value),
    .last_value  (last_value)
  );

endmodule

### rtl/scr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps

module scr_checker
  import scr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [63:0] frame_time,
  input logic [3:0]  value_index,
  input logic [15:0] joint_value,
  input logic        last_value
);

  // A stalled result word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(frame_time) && $stable(joint_value) &&
                               $stable(value_index))
    else $error("result payload changed while stalled");

  // Within a frame, indexes step by one under a fixed timestamp.
  a_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last_value |=>
      res_valid && $stable(frame_time) && (value_index == $past(value_index) + 4'd1))
    else $error("frame words out of sequence");

  // The last mark sits on the final index, and the frame ends after it.
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && last_value |-> value_index == LAST_INDEX ##1 !res_valid)
    else $error("frame end misplaced");

endmodule

bind sync_crc_frame_receiver scr_checker u_scr_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .frame_time  (frame_time),
  .value_index (value_index),
  .joint_value (joint_value),
  .last_value  (last_value)
);
